// ===== src/assert_macros.svh =====
// Assertion shorthands for the RTL; included by the divider top level.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sdiv_pkg.sv =====
// Shared types and codes for the signed non-restoring divider.
// No dependencies; used by the response interface, the cells, the correction stages and the top level.
package sdiv_pkg;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_DIV0 = 2'd1,
		STAT_OVF  = 2'd2
	} status_t;

	// Control that travels alongside the data through every stage.
	typedef struct packed {
		logic    valid;
		logic    xneg;
		logic    qneg;
		status_t status;
	} ctl_t;

endpackage

// ===== src/sdiv_if.sv =====
// Request and response channel interfaces of the divider.
// Depends on sdiv_pkg for the status code type.
interface sdiv_req_if #(parameter int WIDTH = 8);
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] dividend;
	logic signed [WIDTH-1:0] divisor;

	modport source (output valid, dividend, divisor, input ready);
	modport sink   (input valid, dividend, divisor, output ready);
endinterface

interface sdiv_rsp_if #(parameter int WIDTH = 8);
	import sdiv_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [WIDTH-1:0] quotient;
	logic signed [WIDTH-1:0] remainder;
	status_t                 status;

	modport source (output valid, quotient, remainder, status, input ready);
	modport sink   (input valid, quotient, remainder, status, output ready);
endinterface

// ===== src/signed_nonrestoring_divider.sv =====
// Signed divider, fully pipelined: one beat per cycle in and out, with one operand stage,
// one non-restoring cell per quotient bit and two correction stages.
// Quotient truncates toward zero, the remainder takes the dividend's sign; a zero divisor
// gives an all-ones quotient, the dividend as remainder and status 1, and the most
// negative value over minus one wraps with status 2. The whole pipe stalls together
// while a response beat waits, so the request side is ready whenever the output is free.
module signed_nonrestoring_divider #(
	parameter int WIDTH = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	sdiv_req_if.sink  req,
	sdiv_rsp_if.source rsp
);
	import sdiv_pkg::*;
	`include "assert_macros.svh"

	localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

	logic en;

	logic             xneg;
	logic             yneg;
	logic [WIDTH-1:0] ux;
	logic [WIDTH-1:0] uy;
	status_t          stat;

	ctl_t             ctl_s0;
	logic [WIDTH-1:0] ux_s0;
	logic [WIDTH-1:0] uy_s0;

	ctl_t             ctl_c [WIDTH+1];
	logic [WIDTH+1:0] r_c   [WIDTH+1];
	logic [WIDTH-1:0] n_c   [WIDTH+1];
	logic [WIDTH-1:0] q_c   [WIDTH+1];
	logic [WIDTH-1:0] d_c   [WIDTH+1];

	ctl_t             ctl_out;
	logic [WIDTH-1:0] quo_out;
	logic [WIDTH-1:0] rem_out;

	assign en        = !ctl_out.valid || rsp.ready;
	assign req.ready = en;

	always_comb begin
		xneg = req.dividend[WIDTH-1];
		yneg = req.divisor[WIDTH-1];
		ux   = xneg ? (~req.dividend + 1'b1) : req.dividend;
		uy   = yneg ? (~req.divisor + 1'b1) : req.divisor;
		if (req.divisor == '0) begin
			stat = STAT_DIV0;
		end else if (req.dividend == MOST_NEG && req.divisor == '1) begin
			stat = STAT_OVF;
		end else begin
			stat = STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else if (en) begin
			ctl_s0.valid  <= req.valid;
			ctl_s0.xneg   <= xneg;
			ctl_s0.qneg   <= xneg ^ yneg;
			ctl_s0.status <= stat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s0 <= ux;
			uy_s0 <= uy;
		end
	end

	assign ctl_c[0] = ctl_s0;
	assign r_c[0]   = '0;
	assign n_c[0]   = ux_s0;
	assign q_c[0]   = '0;
	assign d_c[0]   = uy_s0;

	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		sdiv_cell #(.W(WIDTH)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (ctl_c[i]),
			.r_i    (r_c[i]),
			.n_i    (n_c[i]),
			.q_i    (q_c[i]),
			.d_i    (d_c[i]),
			.ctl_o  (ctl_c[i+1]),
			.r_o    (r_c[i+1]),
			.n_o    (n_c[i+1]),
			.q_o    (q_c[i+1]),
			.d_o    (d_c[i+1])
		);
	end

	sdiv_fix #(.W(WIDTH)) u_fix (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (ctl_c[WIDTH]),
		.r_i    (r_c[WIDTH]),
		.q_i    (q_c[WIDTH]),
		.d_i    (d_c[WIDTH]),
		.ctl_o  (ctl_out),
		.quo_o  (quo_out),
		.rem_o  (rem_out)
	);

	assign rsp.valid     = ctl_out.valid;
	assign rsp.quotient  = quo_out;
	assign rsp.remainder = rem_out;
	assign rsp.status    = ctl_out.status;

	`ASSERT_IMPLIES(a_div0_quotient, rsp.valid && rsp.status == STAT_DIV0,
		rsp.quotient == '1, "zero divisor must give an all-ones quotient")
	`ASSERT_IMPLIES(a_ovf_result, rsp.valid && rsp.status == STAT_OVF,
		rsp.quotient == MOST_NEG && rsp.remainder == '0, "overflow result must wrap")
	`ASSERT_IMPLIES(a_ready_when_free, !rsp.valid, req.ready,
		"request side must be ready while no response is held")
	`ASSERT_NEXT(a_accept_enters, req.valid && req.ready, ctl_s0.valid,
		"an accepted beat must enter the operand stage")

endmodule

// ===== src/sdiv_cell.sv =====
// One non-restoring division step on magnitudes, registered.
// Depends on sdiv_pkg for the control struct.
module sdiv_cell #(
	parameter int W = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  sdiv_pkg::ctl_t  ctl_i,
	input  logic [W+1:0]    r_i,
	input  logic [W-1:0]    n_i,
	input  logic [W-1:0]    q_i,
	input  logic [W-1:0]    d_i,
	output sdiv_pkg::ctl_t  ctl_o,
	output logic [W+1:0]    r_o,
	output logic [W-1:0]    n_o,
	output logic [W-1:0]    q_o,
	output logic [W-1:0]    d_o
);
	import sdiv_pkg::*;

	logic [W+1:0] sh;
	logic [W+1:0] dx;
	logic [W+1:0] r_nxt;

	ctl_t         ctl_s1;
	logic [W+1:0] r_s1;
	logic [W-1:0] n_s1;
	logic [W-1:0] q_s1;
	logic [W-1:0] d_s1;

	// Shift in the next dividend bit, then subtract the divisor when the
	// partial remainder is non-negative and add it back when negative.
	always_comb begin
		sh = {r_i[W:0], n_i[W-1]};
		dx = {2'b00, d_i};
		if (r_i[W+1]) begin
			r_nxt = sh + dx;
		end else begin
			r_nxt = sh - dx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r_nxt;
			n_s1 <= {n_i[W-2:0], 1'b0};
			q_s1 <= {q_i[W-2:0], ~r_nxt[W+1]};
			d_s1 <= d_i;
		end
	end

	assign ctl_o = ctl_s1;
	assign r_o   = r_s1;
	assign n_o   = n_s1;
	assign q_o   = q_s1;
	assign d_o   = d_s1;

endmodule

// ===== src/sdiv_fix.sv =====
// Remainder and sign correction after the last division step, two stages.
// Depends on sdiv_pkg for the control struct and status codes.
module sdiv_fix #(
	parameter int W = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  sdiv_pkg::ctl_t  ctl_i,
	input  logic [W+1:0]    r_i,
	input  logic [W-1:0]    q_i,
	input  logic [W-1:0]    d_i,
	output sdiv_pkg::ctl_t  ctl_o,
	output logic [W-1:0]    quo_o,
	output logic [W-1:0]    rem_o
);
	import sdiv_pkg::*;

	logic [W+1:0] r_corr;
	logic [W-1:0] quo_nxt;
	logic [W-1:0] rem_nxt;

	ctl_t         ctl_s1;
	logic [W-1:0] rem_s1;
	logic [W-1:0] quo_s1;
	ctl_t         ctl_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] rem_q;

	// A negative final partial remainder gets the divisor added back.
	always_comb begin
		if (r_i[W+1]) begin
			r_corr = r_i + {2'b00, d_i};
		end else begin
			r_corr = r_i;
		end
	end

	// With a zero divisor the steps leave the dividend magnitude in the
	// remainder, so signing it restores the dividend itself.
	always_comb begin
		if (ctl_s1.status == STAT_DIV0) begin
			quo_nxt = '1;
		end else if (ctl_s1.qneg) begin
			quo_nxt = ~quo_s1 + 1'b1;
		end else begin
			quo_nxt = quo_s1;
		end
		if (ctl_s1.xneg) begin
			rem_nxt = ~rem_s1 + 1'b1;
		end else begin
			rem_nxt = rem_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_q  <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_q  <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= r_corr[W-1:0];
			quo_s1 <= q_i;
			quo_q  <= quo_nxt;
			rem_q  <= rem_nxt;
		end
	end

	assign ctl_o = ctl_q;
	assign quo_o = quo_q;
	assign rem_o = rem_q;

endmodule
